@@ rtl/core/gmt_pkg.sv @@
// Package for the gossip membership table merge block.
// Holds widths, reset constants, status codes, register indexes and the sequencer states.
// No dependencies; gmt_if and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package gmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int HB_W    = 31;
    localparam int TIME_W  = 31;
    localparam int STATUS_W = 3;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [TIME_W-1:0] SELF_RESET_TIME = TIME_W'(20);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SELF_ADDRESS = 1'b0,
        REG_SELF_PORT    = 1'b1
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED = 3'd0,
        ST_STALE     = 3'd1,
        ST_ADDED     = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_OWN       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } gmt_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   heartbeat;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/gmt_if.sv @@
// Valid/ready channel interfaces for the merge item beat and the result beat.
// Depends on gmt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gmt_item_if import gmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] peer_address;
    logic [PORT_W-1:0] peer_port;
    logic [HB_W-1:0]   heartbeat;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output mode, output peer_address, output peer_port,
                    output heartbeat, output now_time, input ready);
    modport sink   (input valid, input mode, input peer_address, input peer_port,
                    input heartbeat, input now_time, output ready);
endinterface

interface gmt_result_if import gmt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_index, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input entry_index, input entry_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/gmt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/gossip_membership_table_merge_top.sv @@
// Top level of the gossip membership table merge block: sequencer, entry table RAM,
// own-entry registers and the result register.
// Depends on gmt_pkg, gmt_if (gmt_item_if, gmt_result_if) and gmt_ram.
//
//   Port     Kind           Beat contents
//   item     valid/ready    mode, peer_address, peer_port, heartbeat, now_time
//   result   valid/ready    status, entry_index, entry_count
//   cfg_*    write only     cfg_index 0 self_address, 1 self_port
//
// A merge beat occupies the block while the sequencer compares the table entries in turn,
// as the stored entries come one a cycle through the RAM read port.
// An own-tick beat skips the scan. item.ready is high only while the sequencer is idle.
// After reset the table holds entry zero only; no clearing pass is run.
// A result waits in the output register; the next beat is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module gossip_membership_table_merge_top import gmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    gmt_item_if.sink                    item,
    gmt_result_if.source                result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int ENTRY_W = $bits(entry_t);

    gmt_state_t        state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0] self_addr_reg;
    logic [PORT_W-1:0] self_port_reg;
    logic [HB_W-1:0]   self_hb_reg, self_hb_next;
    logic [TIME_W-1:0] self_time_reg, self_time_next;

    logic [ADDR_W-1:0] req_addr_reg;
    logic [PORT_W-1:0] req_port_reg;
    logic [HB_W-1:0]   req_hb_reg;
    logic [TIME_W-1:0] req_time_reg;

    status_t           res_status_reg, res_status_next;
    logic [IW-1:0]     res_index_reg, res_index_next;

    logic              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic              out_load;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t            cur;
    logic              at_end;
    logic              hit;
    logic [IW+INDEX_W-1:0] index_wide;
    logic [CW+COUNT_W-1:0] count_wide;

    gmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry zero lives in registers; the RAM copy at index zero is never used.
    always_comb
    begin
        if (idx_reg == '0)
        begin
            cur = '{address: self_addr_reg, port: self_port_reg,
                    heartbeat: self_hb_reg, stamp: self_time_reg};
        end
        else
        begin
            cur = entry_t'(ram_rdata);
        end
    end

    assign at_end = (idx_reg >= count_reg);
    assign hit    = (cur.address == req_addr_reg) && (cur.port == req_port_reg);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        self_hb_next    = self_hb_reg;
        self_time_next  = self_time_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IW-1:0];
        ram_wdata       = '{address: req_addr_reg, port: req_port_reg,
                            heartbeat: req_hb_reg, stamp: req_time_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.mode)
                    begin
                        self_hb_next    = item.heartbeat;
                        self_time_next  = item.now_time;
                        res_status_next = ST_OWN;
                        res_index_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (at_end)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = count_reg[IW-1:0];
                        count_next      = count_reg + CW'(1);
                        res_status_next = ST_ADDED;
                        res_index_next  = count_reg[IW-1:0];
                    end
                    else
                    begin
                        res_status_next = ST_DROPPED;
                        res_index_next  = '0;
                    end
                    state_next = S_DONE;
                end
                else if (hit)
                begin
                    res_index_next = idx_reg[IW-1:0];
                    if (req_hb_reg > cur.heartbeat)
                    begin
                        res_status_next = ST_REFRESHED;
                        if (idx_reg == '0)
                        begin
                            self_hb_next   = req_hb_reg;
                            self_time_next = req_time_reg;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_STALE;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The read address runs one entry ahead so the data for idx_reg is ready in S_SCAN.
    assign ram_raddr = idx_next[IW-1:0];

    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign index_wide = {{INDEX_W{1'b0}}, res_index_reg};
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= CW'(1);
            self_addr_reg <= '0;
            self_port_reg <= '0;
            self_hb_reg   <= '0;
            self_time_reg <= SELF_RESET_TIME;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            self_hb_reg   <= self_hb_next;
            self_time_reg <= self_time_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SELF_ADDRESS: self_addr_reg <= cfg_data;
                    REG_SELF_PORT:    self_port_reg <= cfg_data[PORT_W-1:0];
                    default:          self_addr_reg <= self_addr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            req_addr_reg <= item.peer_address;
            req_port_reg <= item.peer_port;
            req_hb_reg   <= item.heartbeat;
            req_time_reg <= item.now_time;
        end
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= index_wide[INDEX_W-1:0];
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.entry_index = out_index_reg;
    assign result.entry_count = out_count_reg;

    // The table always holds entry zero and never more than its depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= DEPTH_C))
        else $error("valid count out of range");

    // Entries are only ever appended, one per item.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("valid count changed by other than one");

    // The search never runs past the first free entry.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= count_reg))
        else $error("search index beyond valid count");

    // The table is written only while a merge is being decided.
    a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN) && ((idx_reg != '0) || at_end))
        else $error("table write outside a merge decision");

endmodule

`default_nettype wire
